### rtl/core/zero_suppressed_bunch_encoder_unit_macros.svh
// assertion macros shared by the bunch encoder rtl
// no dependencies; each user module provides aclk and aresetn
`ifndef ZERO_SUPPRESSED_BUNCH_ENCODER_UNIT_MACROS_SVH
`define ZERO_SUPPRESSED_BUNCH_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ZSBE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("zsbe assertion failed");

// next-cycle implication, checked out of reset
`define ZSBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("zsbe assertion failed");

`endif

### rtl/core/zsbe_pkg.sv
// shared types, constants and helper functions of the bunch encoder
// no dependencies; imported by every module of the block
`default_nettype none

package zsbe_pkg;

    localparam int INNER_SECTORS = 36;
    localparam logic [6:0] INNER_SEC = 7'(INNER_SECTORS);
    localparam logic [10:0] BUNCH_MAX = 11'd2045;
    localparam logic [11:0] COUNT_MAX = 12'd4095;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [2:0] {
        KIND_SAMPLE  = 3'd0,
        KIND_END     = 3'd1,
        KIND_LEN     = 3'd2,
        KIND_TRAILER = 3'd3,
        KIND_OPEN    = 3'd4,
        KIND_CLOSE   = 3'd5
    } kind_t;

    // result slots of one command, lowest bit goes out first
    localparam int MB_END    = 0;
    localparam int MB_LEN    = 1;
    localparam int MB_TRL    = 2;
    localparam int MB_CLOSE  = 3;
    localparam int MB_OPEN   = 4;
    localparam int MB_SAMPLE = 5;
    localparam int MB_N      = 6;

    typedef struct packed {
        logic [9:0]  time_bin;
        logic [9:0]  adc_value;
        logic [7:0]  pad;
        logic [7:0]  row;
        logic [1:0]  subsector;
        logic [6:0]  sector;
        logic        op;
    } in_item_t;

    typedef struct packed {
        logic [MB_N-1:0] mask;
        logic [9:0]      end_time;
        logic [10:0]     len_word;
        logic [11:0]     trl_words;
        logic [7:0]      trl_pad;
        logic [7:0]      trl_row;
        logic [6:0]      trl_sector;
        logic [7:0]      close_link;
        logic [7:0]      open_link;
        logic [9:0]      adc_value;
    } cmd_t;

    function automatic logic [7:0] link_of(input logic [6:0] sec, input logic [1:0] sub);
        logic [9:0] n;
        if (sec < INNER_SEC) begin
            n = {2'b00, sec, 1'b0} + {8'b0, sub};
        end else begin
            n = 10'(2 * INNER_SECTORS) + {1'b0, 7'(sec - INNER_SEC), 2'b00} + {8'b0, sub};
        end
        return n[7:0];
    endfunction

    function automatic logic [11:0] count_add(input logic [11:0] c, input logic [1:0] k);
        logic [12:0] s;
        s = {1'b0, c} + {11'b0, k};
        return s[12] ? COUNT_MAX : s[11:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/zsbe_front.sv
// front end: tracks channel, bunch and link state per accepted item
// and turns each item into at most one command for the back end; uses zsbe_pkg
`default_nettype none

module zsbe_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_valid,
    input  wire zsbe_pkg::in_item_t item,
    output logic                   item_ready,
    input  wire logic              fifo_full,
    output logic                   push,
    output zsbe_pkg::cmd_t         cmd
);
    import zsbe_pkg::*;

    logic        started_reg, started_next;
    logic [6:0]  prev_sector_reg, prev_sector_next;
    logic [1:0]  prev_subsector_reg, prev_subsector_next;
    logic [7:0]  prev_row_reg, prev_row_next;
    logic [7:0]  prev_pad_reg, prev_pad_next;
    logic [9:0]  prev_time_reg, prev_time_next;
    logic [10:0] bunch_length_reg, bunch_length_next;
    logic [11:0] pad_word_count_reg, pad_word_count_next;
    logic [7:0]  current_link_reg, current_link_next;

    logic accept;
    logic same_chan;
    logic cont;
    logic [7:0] new_link;

    assign item_ready = !fifo_full;
    assign accept = item_valid && item_ready;
    assign new_link = link_of(item.sector, item.subsector);
    assign same_chan = (item.pad == prev_pad_reg) && (item.row == prev_row_reg)
                    && (item.sector == prev_sector_reg);
    // 11-bit compare so that time bin 1023 never continues
    assign cont = same_chan && ({1'b0, item.time_bin} == ({1'b0, prev_time_reg} + 11'd1));

    always_comb begin
        started_next        = started_reg;
        prev_sector_next    = prev_sector_reg;
        prev_subsector_next = prev_subsector_reg;
        prev_row_next       = prev_row_reg;
        prev_pad_next       = prev_pad_reg;
        prev_time_next      = prev_time_reg;
        bunch_length_next   = bunch_length_reg;
        pad_word_count_next = pad_word_count_reg;
        current_link_next   = current_link_reg;

        cmd            = '0;
        cmd.end_time   = prev_time_reg;
        cmd.len_word   = bunch_length_reg + 11'd2;
        cmd.trl_words  = count_add(pad_word_count_reg, 2'd2);
        cmd.trl_pad    = prev_pad_reg;
        cmd.trl_row    = prev_row_reg;
        cmd.trl_sector = prev_sector_reg;
        cmd.close_link = current_link_reg;
        cmd.open_link  = new_link;
        cmd.adc_value  = item.adc_value;

        if (item.op) begin
            if (started_reg) begin
                cmd.mask[MB_END]   = 1'b1;
                cmd.mask[MB_LEN]   = 1'b1;
                cmd.mask[MB_TRL]   = 1'b1;
                cmd.mask[MB_CLOSE] = 1'b1;
                started_next        = 1'b0;
                prev_sector_next    = '0;
                prev_subsector_next = '0;
                prev_row_next       = '0;
                prev_pad_next       = '0;
                prev_time_next      = '0;
                bunch_length_next   = '0;
                pad_word_count_next = '0;
                current_link_next   = '0;
            end
        end else begin
            cmd.mask[MB_SAMPLE] = 1'b1;
            prev_time_next      = item.time_bin;
            if (!started_reg) begin
                cmd.mask[MB_OPEN]   = 1'b1;
                started_next        = 1'b1;
                prev_sector_next    = item.sector;
                prev_subsector_next = item.subsector;
                prev_row_next       = item.row;
                prev_pad_next       = item.pad;
                current_link_next   = new_link;
                bunch_length_next   = 11'd1;
                pad_word_count_next = 12'd1;
            end else if (cont) begin
                if (bunch_length_reg < BUNCH_MAX) begin
                    bunch_length_next = bunch_length_reg + 11'd1;
                end
                pad_word_count_next = count_add(pad_word_count_reg, 2'd1);
            end else begin
                cmd.mask[MB_END] = 1'b1;
                cmd.mask[MB_LEN] = 1'b1;
                bunch_length_next = 11'd1;
                prev_pad_next     = item.pad;
                prev_row_next     = item.row;
                prev_sector_next  = item.sector;
                if (same_chan) begin
                    pad_word_count_next = count_add(pad_word_count_reg, 2'd3);
                end else begin
                    cmd.mask[MB_TRL]    = 1'b1;
                    pad_word_count_next = 12'd1;
                    if (item.subsector != prev_subsector_reg) begin
                        cmd.mask[MB_CLOSE]  = 1'b1;
                        cmd.mask[MB_OPEN]   = 1'b1;
                        current_link_next   = new_link;
                        prev_subsector_next = item.subsector;
                    end
                end
            end
        end
    end

    // a flush while idle has nothing to say
    assign push = accept && (cmd.mask != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg        <= 1'b0;
            prev_sector_reg    <= '0;
            prev_subsector_reg <= '0;
            prev_row_reg       <= '0;
            prev_pad_reg       <= '0;
            prev_time_reg      <= '0;
            bunch_length_reg   <= '0;
            pad_word_count_reg <= '0;
            current_link_reg   <= '0;
        end else if (accept) begin
            started_reg        <= started_next;
            prev_sector_reg    <= prev_sector_next;
            prev_subsector_reg <= prev_subsector_next;
            prev_row_reg       <= prev_row_next;
            prev_pad_reg       <= prev_pad_next;
            prev_time_reg      <= prev_time_next;
            bunch_length_reg   <= bunch_length_next;
            pad_word_count_reg <= pad_word_count_next;
            current_link_reg   <= current_link_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/zsbe_fifo.sv
// command queue between front and back end, register based
// depth and entry type come from zsbe_pkg
`default_nettype none

module zsbe_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire zsbe_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output zsbe_pkg::cmd_t      head,
    output logic                head_valid,
    output logic                full
);
    import zsbe_pkg::*;

    cmd_t entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/core/zsbe_back.sv
// back end: expands queued commands into result words through a registered
// output stage, one per cycle unless stalled; uses zsbe_pkg and assertion macros
`default_nettype none
`include "zero_suppressed_bunch_encoder_unit_macros.svh"

module zsbe_back (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire zsbe_pkg::cmd_t            head,
    input  wire logic                      head_valid,
    output logic                           pop,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [zsbe_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [2:0]                     m_tuser,
    output logic                           m_tlast
);
    import zsbe_pkg::*;

    logic [MB_N-1:0] done_reg, done_next;
    logic [MB_N-1:0] remaining;
    logic [MB_N-1:0] sel;
    logic            load;
    logic            final_one;

    logic        m_valid_reg;
    kind_t       m_kind_reg, m_kind_next;
    logic [10:0] m_word_reg, m_word_next;
    logic [7:0]  m_link_reg, m_link_next;
    logic [11:0] m_tw_reg, m_tw_next;
    logic [7:0]  m_tp_reg, m_tp_next;
    logic [7:0]  m_tr_reg, m_tr_next;
    logic [6:0]  m_ts_reg, m_ts_next;
    logic        m_last_reg;

    assign remaining = head.mask & ~done_reg;
    assign load      = head_valid && (!m_valid_reg || m_tready);
    assign final_one = ((remaining & ~sel) == '0);
    assign pop       = load && final_one;

    always_comb begin
        sel = '0;
        priority if (remaining[MB_END])    sel[MB_END]    = 1'b1;
        else if     (remaining[MB_LEN])    sel[MB_LEN]    = 1'b1;
        else if     (remaining[MB_TRL])    sel[MB_TRL]    = 1'b1;
        else if     (remaining[MB_CLOSE])  sel[MB_CLOSE]  = 1'b1;
        else if     (remaining[MB_OPEN])   sel[MB_OPEN]   = 1'b1;
        else                               sel[MB_SAMPLE] = 1'b1;
    end

    always_comb begin
        m_kind_next = KIND_SAMPLE;
        m_word_next = '0;
        m_link_next = '0;
        m_tw_next   = '0;
        m_tp_next   = '0;
        m_tr_next   = '0;
        m_ts_next   = '0;
        unique case (1'b1)
            sel[MB_END]: begin
                m_kind_next = KIND_END;
                m_word_next = {1'b0, head.end_time};
            end
            sel[MB_LEN]: begin
                m_kind_next = KIND_LEN;
                m_word_next = head.len_word;
            end
            sel[MB_TRL]: begin
                m_kind_next = KIND_TRAILER;
                m_tw_next   = head.trl_words;
                m_tp_next   = head.trl_pad;
                m_tr_next   = head.trl_row;
                m_ts_next   = head.trl_sector;
            end
            sel[MB_CLOSE]: begin
                m_kind_next = KIND_CLOSE;
                m_link_next = head.close_link;
            end
            sel[MB_OPEN]: begin
                m_kind_next = KIND_OPEN;
                m_link_next = head.open_link;
            end
            default: begin
                m_kind_next = KIND_SAMPLE;
                m_word_next = {1'b0, head.adc_value};
            end
        endcase
    end

    always_comb begin
        done_next = done_reg;
        if (load) begin
            done_next = final_one ? '0 : (done_reg | sel);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_kind_reg <= m_kind_next;
            m_word_reg <= m_word_next;
            m_link_reg <= m_link_next;
            m_tw_reg   <= m_tw_next;
            m_tp_reg   <= m_tp_next;
            m_tr_reg   <= m_tr_next;
            m_ts_reg   <= m_ts_next;
            m_last_reg <= final_one;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_ts_reg, m_tr_reg, m_tp_reg, m_tw_reg, m_link_reg, m_word_reg};

    `ZSBE_ASSERT_SAME(a_pop_needs_head, pop, head_valid)
    `ZSBE_ASSERT_SAME(a_single_slot_pops, load && $onehot(remaining), pop)
    `ZSBE_ASSERT_SAME(a_sample_is_last, m_valid_reg && (m_kind_reg == KIND_SAMPLE), m_last_reg)
    `ZSBE_ASSERT_SAME(a_open_not_last, m_valid_reg && (m_kind_reg == KIND_OPEN), !m_last_reg)

endmodule

`default_nettype wire

### rtl/core/zero_suppressed_bunch_encoder_unit.sv
// path: an input transfer's results reach m_ through the command queue and the output register
// throughput: one input transfer and one result transfer per cycle, save when the queue is full
// or m_tready stalls; an item's k results hold the back end; a four-entry queue absorbs bursts
// reset: synchronous active-low aresetn clears channel state, queue and output stage
// depends on zsbe_pkg, zsbe_front, zsbe_fifo and zsbe_back
`default_nettype none

module zero_suppressed_bunch_encoder_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // sector, subsector, row, pad, time_bin, adc_value, zero fill
    input  wire logic [zsbe_pkg::IN_TDATA_W-1:0]     s_tdata,
    // op
    input  wire logic [0:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // word, link_number, trailer_words, trailer_pad, trailer_row, trailer_sector, zero fill
    output logic [zsbe_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // kind
    output logic [2:0]                               m_tuser,
    output logic                                     m_tlast
);
    import zsbe_pkg::*;

    in_item_t item;
    cmd_t     push_cmd;
    cmd_t     head;
    logic     push;
    logic     pop;
    logic     head_valid;
    logic     fifo_full;

    assign item.op        = s_tuser[0];
    assign item.sector    = s_tdata[6:0];
    assign item.subsector = s_tdata[8:7];
    assign item.row       = s_tdata[16:9];
    assign item.pad       = s_tdata[24:17];
    assign item.time_bin  = s_tdata[34:25];
    assign item.adc_value = s_tdata[44:35];

    zsbe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_tvalid),
        .item       (item),
        .item_ready (s_tready),
        .fifo_full  (fifo_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    zsbe_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (fifo_full)
    );

    zsbe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

### dv/zero_suppressed_bunch_encoder_unit_tb.sv
// self-checking testbench for the zero-suppressed bunch encoder unit
// drives sample and flush transfers, predicts every output word, stalls both streams at random
// depends on zsbe_pkg and zero_suppressed_bunch_encoder_unit
`default_nettype none

module zero_suppressed_bunch_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zsbe_pkg::*;

    localparam bit OP_SAMPLE = 1'b0;
    localparam bit OP_FLUSH = 1'b1;
    localparam int SAT_BUNCH = 2045;
    localparam int SAT_WORDS = 4095;
    localparam int TB_MAX = 1023;
    localparam int RANDOM_ITEMS = 250;
    localparam int SETTLE_CYCLES = 8;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        kind_t      kind;
        logic [10:0] word;
        logic [7:0]  link;
        logic [11:0] t_words;
        logic [7:0]  t_pad;
        logic [7:0]  t_row;
        logic [6:0]  t_sector;
        logic        last;
    } enc_word_t;

    // tracks channel and link state, keeps the words the encoder still owes
    class bunch_word_tracker;
        enc_word_t pending_words[$];
        enc_word_t fresh[$];
        int fails;
        bit started;
        logic [6:0] ch_sector;
        logic [1:0] ch_sub;
        logic [7:0] ch_row;
        logic [7:0] ch_pad;
        logic [9:0] ch_time;
        int bunch_len;
        int pad_words;
        logic [7:0] link_open;

        function new();
            fails = 0;
            clear();
        endfunction

        function void clear();
            started = 1'b0;
            ch_sector = '0;
            ch_sub = '0;
            ch_row = '0;
            ch_pad = '0;
            ch_time = '0;
            bunch_len = 0;
            pad_words = 0;
            link_open = '0;
        endfunction

        function logic [7:0] chan_link(logic [6:0] sec, logic [1:0] sub);
            int n;
            if (int'(sec) < INNER_SECTORS) begin
                n = 2 * int'(sec) + int'(sub);
            end else begin
                n = 2 * INNER_SECTORS + 4 * (int'(sec) - INNER_SECTORS) + int'(sub);
            end
            return 8'(n);
        endfunction

        function void add(kind_t k, int word, logic [7:0] link, int tw, logic [7:0] tp,
                          logic [7:0] tr, logic [6:0] ts);
            enc_word_t w;
            w.kind = k;
            w.word = 11'(word);
            w.link = link;
            w.t_words = 12'(tw);
            w.t_pad = tp;
            w.t_row = tr;
            w.t_sector = ts;
            w.last = 1'b0;
            fresh.push_back(w);
        endfunction

        function void bump_count(int k);
            pad_words = (pad_words + k > SAT_WORDS) ? SAT_WORDS : pad_words + k;
        endfunction

        function void close_bunch();
            add(KIND_END, int'(ch_time), '0, 0, '0, '0, '0);
            add(KIND_LEN, bunch_len + 2, '0, 0, '0, '0, '0);
            bump_count(2);
        endfunction

        function void emit_trailer();
            add(KIND_TRAILER, 0, '0, pad_words, ch_pad, ch_row, ch_sector);
            pad_words = 0;
        endfunction

        function void take_item(bit op, logic [6:0] sec, logic [1:0] sub, logic [7:0] row,
                                logic [7:0] pad, logic [9:0] tb, logic [9:0] adc);
            bit same_chan;
            fresh.delete();
            if (op == OP_FLUSH) begin
                if (started) begin
                    close_bunch();
                    emit_trailer();
                    add(KIND_CLOSE, 0, link_open, 0, '0, '0, '0);
                    clear();
                end
            end else if (!started) begin
                started = 1'b1;
                ch_sector = sec;
                ch_sub = sub;
                ch_row = row;
                ch_pad = pad;
                link_open = chan_link(sec, sub);
                add(KIND_OPEN, 0, link_open, 0, '0, '0, '0);
                bunch_len = 1;
                pad_words = 0;
            end else begin
                same_chan = (pad == ch_pad) && (row == ch_row) && (sec == ch_sector);
                // no wrap: time bin 1023 never continues
                if (same_chan && int'(tb) == int'(ch_time) + 1) begin
                    if (bunch_len < SAT_BUNCH) bunch_len++;
                end else begin
                    close_bunch();
                    if (!same_chan) begin
                        emit_trailer();
                        if (sub != ch_sub) begin
                            add(KIND_CLOSE, 0, link_open, 0, '0, '0, '0);
                            link_open = chan_link(sec, sub);
                            add(KIND_OPEN, 0, link_open, 0, '0, '0, '0);
                            ch_sub = sub;
                        end
                    end
                    bunch_len = 1;
                    ch_pad = pad;
                    ch_row = row;
                    ch_sector = sec;
                end
            end
            if (op == OP_SAMPLE) begin
                ch_time = tb;
                add(KIND_SAMPLE, int'(adc), '0, 0, '0, '0, '0);
                bump_count(1);
            end
            if (fresh.size() > 0) begin
                fresh[fresh.size() - 1].last = 1'b1;
                foreach (fresh[i]) pending_words.push_back(fresh[i]);
            end
        endfunction

        function void cmp(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                fails++;
            end
        endfunction

        function void match_word(enc_word_t got);
            enc_word_t want;
            if (pending_words.size() == 0) begin
                $error("unexpected output transfer, kind %0d word %0d", got.kind, got.word);
                fails++;
                return;
            end
            want = pending_words.pop_front();
            cmp("kind", int'(want.kind), int'(got.kind));
            cmp("word", int'(want.word), int'(got.word));
            cmp("link_number", int'(want.link), int'(got.link));
            cmp("trailer_words", int'(want.t_words), int'(got.t_words));
            cmp("trailer_pad", int'(want.t_pad), int'(got.t_pad));
            cmp("trailer_row", int'(want.t_row), int'(got.t_row));
            cmp("trailer_sector", int'(want.t_sector), int'(got.t_sector));
            cmp("last", int'(want.last), int'(got.last));
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic [0:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [2:0] m_tuser;
    logic m_tlast;

    bunch_word_tracker board;
    bit steady;
    int items_sent;
    longint cycle_count;

    zero_suppressed_bunch_encoder_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // mostly short gaps, now and then a long one; none while steady
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(bit op, logic [6:0] sec, logic [1:0] sub, logic [7:0] row,
                             logic [7:0] pad, logic [9:0] tb, logic [9:0] adc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        // sector, subsector, row, pad, time_bin, adc_value, zero fill
        s_tdata <= {3'b000, adc, tb, pad, row, sub, sec};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.take_item(op, sec, sub, row, pad, tb, adc);
        items_sent++;
    endtask

    task automatic sample(logic [6:0] sec, logic [1:0] sub, logic [7:0] row, logic [7:0] pad,
                          int tb, logic [9:0] adc);
        send_item(OP_SAMPLE, sec, sub, row, pad, 10'(tb), adc);
    endtask

    // flush with junk in the ignored fields
    task automatic flush();
        send_item(OP_FLUSH, 7'($urandom), 2'($urandom), 8'($urandom), 8'($urandom),
                  10'($urandom), 10'($urandom));
    endtask

    task automatic noise_item();
        send_item(1'($urandom), 7'($urandom), 2'($urandom), 8'($urandom), 8'($urandom),
                  10'($urandom), 10'($urandom));
    endtask

    // one readout frame: a few channels, each with a few bunches in time order
    task automatic random_frame();
        int nchan;
        int nb;
        int len;
        int t;
        logic [6:0] sec;
        logic [1:0] sub;
        logic [7:0] row;
        logic [7:0] pad;
        sec = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(72, 127))
                                          : 7'($urandom_range(0, 71));
        sub = 2'($urandom);
        row = 8'($urandom);
        pad = 8'($urandom);
        nchan = $urandom_range(1, 5);
        for (int c = 0; c < nchan; c++) begin
            t = ($urandom_range(0, 7) == 0) ? $urandom_range(1018, TB_MAX)
                                            : $urandom_range(0, TB_MAX);
            nb = $urandom_range(1, 3);
            for (int b = 0; b < nb && t <= TB_MAX; b++) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len && t <= TB_MAX; k++) begin
                    if ($urandom_range(0, 19) == 0) noise_item();
                    sample(sec, sub, row, pad, t, 10'($urandom));
                    t++;
                end
                t += $urandom_range(1, 40);
            end
            case ($urandom_range(0, 5))
                0: begin
                    sub = 2'($urandom);
                end
                1: begin
                    sec = 7'($urandom_range(0, 127));
                end
                2: begin
                    row = 8'($urandom);
                end
                default: begin
                    pad = pad + 8'd1;
                end
            endcase
        end
        if ($urandom_range(0, 9) < 7) flush();
    endtask

    // result side stalls
    initial begin
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        enc_word_t got;
        if (aresetn && m_tvalid && m_tready) begin
            // word, link_number, trailer_words, trailer_pad, trailer_row, trailer_sector
            got.kind = kind_t'(m_tuser);
            got.word = m_tdata[10:0];
            got.link = m_tdata[18:11];
            got.t_words = m_tdata[30:19];
            got.t_pad = m_tdata[38:31];
            got.t_row = m_tdata[46:39];
            got.t_sector = m_tdata[53:47];
            got.last = m_tlast;
            board.match_word(got);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int base;
        board = new();
        steady = 1'b0;
        items_sent = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: flush while idle, link open, continuation, no wrap after bin 1023
        flush();
        sample(7'd0, 2'd0, 8'd0, 8'd0, 0, 10'd0);
        sample(7'd0, 2'd0, 8'd0, 8'd0, 1, 10'd1023);
        sample(7'd0, 2'd0, 8'd0, 8'd0, TB_MAX, 10'd512);
        sample(7'd0, 2'd0, 8'd0, 8'd0, 0, 10'd341);
        // sector change on the same subsector keeps the link
        sample(7'd1, 2'd0, 8'd0, 8'd0, 3, 10'd682);
        // subsector change swaps links
        sample(7'd1, 2'd3, 8'd255, 8'd255, 4, 10'd100);
        sample(7'd1, 2'd3, 8'd254, 8'd255, 4, 10'd101);
        sample(7'd1, 2'd3, 8'd254, 8'd0, 4, 10'd102);
        // link numbering at inner/outer boundary, top sector, beyond range
        sample(7'd35, 2'd2, 8'd10, 8'd20, 7, 10'd7);
        sample(7'd36, 2'd1, 8'd10, 8'd20, 8, 10'd8);
        sample(7'd71, 2'd3, 8'd11, 8'd21, 9, 10'd9);
        sample(7'd127, 2'd0, 8'd12, 8'd22, 10, 10'd10);
        sample(7'd100, 2'd2, 8'd12, 8'd22, 11, 10'd11);
        flush();
        flush();
        sample(7'd71, 2'd3, 8'd255, 8'd255, TB_MAX, 10'd1023);
        flush();

        // a bunch running up to the last time bin, first half with no idling
        steady = 1'b1;
        for (int t = TB_MAX - 31; t <= TB_MAX; t++) begin
            if (t == TB_MAX - 15) steady = 1'b0;
            sample(7'd10, 2'd1, 8'd7, 8'd9, t, 10'($urandom));
        end
        flush();

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) steady = ~steady;
            if ($urandom_range(0, 9) == 0) noise_item();
            else random_frame();
        end
        flush();
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (board.pending_words.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+rtl/core
rtl/core/zsbe_pkg.sv
rtl/core/zsbe_front.sv
rtl/core/zsbe_fifo.sv
rtl/core/zsbe_back.sv
rtl/core/zero_suppressed_bunch_encoder_unit.sv
dv/zero_suppressed_bunch_encoder_unit_tb.sv
